[sv/lspsr_pkg.sv]
// Shared types and constants for the LSP stability check and rearrange block.
// Holds the sequencer state enums and the default sizes; no dependencies.
`timescale 1ns / 1ps

package lspsr_pkg;

    // Default sizes handed to the top-level parameters
    localparam int MAX_ORDER_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 16;

    // Order register: fixed width and reset value
    localparam int         ORDER_W     = 6;
    localparam logic [5:0] ORDER_RESET = 6'd24;

    // Top-level sequencer: load, wait on sort, fetch and present results
    typedef enum logic [1:0] {
        T_LOAD,
        T_SORT,
        T_EFETCH,
        T_EHOLD
    } t_top_state;

    // Rank sorter sequencer: fetch key, capture key, scan all entries
    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_CAP,
        S_SCAN
    } t_sort_state;

endpackage

[sv/lsp_stability_check_and_rearrange_unit.sv]
// LSP stability check and rearrange, top level: stream ports, load, check, fold, emit.
// Depends on lspsr_pkg and lspsr_sorter.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream (i_s_*): one signed Q15 LSP value per transfer, in tdata.
//   The vector closes when the number of loaded values reaches the effective
//   order (order register, zero taken as one, capped at MAX_ORDER).
//   Each value is range and order checked while loading, then folded into
//   0..0.5 and stored.
//   Output stream (o_m_*): the folded values in ascending order, tlast on
//   the final one, tuser carrying the vector's ill-condition flag.
//   Config: i_cfg_we writes i_cfg_wdata into the order register; write only
//   while the block is idle.
// Timing:
//   Loading takes one value per cycle while i_s_tvalid is high (tready high throughout).
//   Sorting: one comparator counts each entry's rank against all n
//   entries, after a key fetch and key capture for each entry.
//   Emission reads each result from the sorted store, then presents it.
//   A stalled receiver holds the current result; nothing new is taken until
//   the last result transfers.
// Reset: synchronous, active low; clears the sequencer, load count, previous
//   value and flag, and sets order to 24.

module lsp_stability_check_and_rearrange_unit
    import lspsr_pkg::*;
#(
    parameter int MAX_ORDER   = MAX_ORDER_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IN_TW      = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW     = ((VALUE_WIDTH - 1 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Config port
    input  logic               i_cfg_we,
    input  logic [ORDER_W-1:0] i_cfg_wdata,   // [5:0] order
    // Input stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [IN_TW-1:0]   i_s_tdata,     // [VALUE_WIDTH-1:0] lsp_value, rest zero
    // Output stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_TW-1:0]  o_m_tdata,     // [VALUE_WIDTH-2:0] arranged_value, rest zero
    output logic               o_m_tlast,
    output logic               o_m_tuser      // [0] ill_condition
);

    localparam int VW = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH - 1;
    localparam int AW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);

    localparam logic [VW-1:0] Q_ONE  = {1'b1, {(VW - 1){1'b0}}};
    localparam logic [VW-1:0] Q_HALF = {2'b01, {(VW - 2){1'b0}}};

    t_top_state           r_state, n_state;
    logic [ORDER_W-1:0]   r_order;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_n, n_n;
    logic [AW-1:0]        r_k, n_k;
    logic signed [VW-1:0] r_prev, n_prev;
    logic                 r_bad, n_bad;

    logic [CW-1:0]        eff;
    logic signed [VW-1:0] in_val;
    logic                 bad_now;
    logic [CW-1:0]        cnt_inc;
    logic                 s_xfer;
    logic                 m_xfer;
    logic                 last_k;

    logic                 wr_en;
    logic                 sort_start;
    logic                 sort_done;
    logic [AW-1:0]        rd_addr;
    logic [DW-1:0]        rd_data;

    // Negate negatives (saturating), reflect values above one half
    function automatic logic [DW-1:0] fold(input logic [VW-1:0] v);
        logic [VW-1:0] mag;
        logic [VW-1:0] res;
        if (v[VW-1]) begin
            mag = (v == Q_ONE) ? (Q_ONE - 1'b1) : (~v + 1'b1);
        end else begin
            mag = v;
        end
        res = (mag > Q_HALF) ? (Q_ONE - mag) : mag;
        return res[DW-1:0];
    endfunction

    // Hold the order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Effective order: zero reads as one, capped at the store depth
    always_comb begin
        if (r_order == '0) begin
            eff = CW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            eff = CW'(MAX_ORDER);
        end else begin
            eff = CW'(r_order);
        end
    end

    assign in_val  = i_s_tdata[VW-1:0];
    assign s_xfer  = o_s_tready && i_s_tvalid;
    assign m_xfer  = o_m_tvalid && i_m_tready;
    assign cnt_inc = r_cnt + CW'(1);
    assign last_k  = (CW'(r_k) + CW'(1)) == r_n;

    // Stability test: strictly inside (0, 0.5) and strictly increasing
    assign bad_now = in_val[VW-1] || (in_val == '0)
                   || (!in_val[VW-1] && (VW'(in_val) >= Q_HALF))
                   || ((r_cnt != '0) && (in_val <= r_prev));

    // Hold sequencer state and vector status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_LOAD;
            r_cnt   <= '0;
            r_prev  <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_prev  <= n_prev;
            r_bad   <= n_bad;
        end
        r_n <= n_n;
        r_k <= n_k;
    end

    // Advance load, sort and emission
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_k        = r_k;
        n_prev     = r_prev;
        n_bad      = r_bad;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        wr_en      = 1'b0;
        sort_start = 1'b0;
        rd_addr    = r_k;
        case (r_state)
            T_LOAD: begin
                o_s_tready = 1'b1;
                if (s_xfer) begin
                    wr_en  = 1'b1;
                    n_prev = in_val;
                    n_bad  = r_bad | bad_now;
                    if (cnt_inc >= eff) begin
                        sort_start = 1'b1;
                        n_n        = cnt_inc;
                        n_state    = T_SORT;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            T_SORT: begin
                if (sort_done) begin
                    n_k     = '0;
                    n_state = T_EFETCH;
                end
            end
            T_EFETCH: begin
                n_state = T_EHOLD;
            end
            T_EHOLD: begin
                o_m_tvalid = 1'b1;
                if (m_xfer) begin
                    if (last_k) begin
                        n_cnt   = '0;
                        n_prev  = '0;
                        n_bad   = 1'b0;
                        n_state = T_LOAD;
                    end else begin
                        n_k     = AW'(r_k + 1'b1);
                        n_state = T_EFETCH;
                    end
                end
            end
            default: begin
                n_state = T_LOAD;
            end
        endcase
    end

    // Present the current result
    assign o_m_tdata = OUT_TW'(rd_data);
    assign o_m_tlast = o_m_tvalid && last_k;
    assign o_m_tuser = r_bad;

    lspsr_sorter #(
        .MAX_ORDER (MAX_ORDER),
        .DW        (DW)
    ) u_sorter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (fold(in_val)),
        .i_start   (sort_start),
        .i_count   (cnt_inc),
        .o_done    (sort_done),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

[sv/lspsr_sorter.sv]
// Rank sorter: value store plus sorted store, one shared comparator.
// Each entry's rank is counted over all entries, then the entry is written at its rank.
// Depends on lspsr_pkg.
`timescale 1ns / 1ps

module lspsr_sorter
    import lspsr_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int DW        = VALUE_WIDTH_DEF - 1,
    localparam int AW       = $clog2(MAX_ORDER),
    localparam int CW       = $clog2(MAX_ORDER + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_start,
    input  logic [CW-1:0] i_count,
    output logic          o_done,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem_val [MAX_ORDER];
    logic [DW-1:0] mem_srt [MAX_ORDER];

    t_sort_state   r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_rank, n_rank;
    logic [DW-1:0] r_key, n_key;
    logic [DW-1:0] r_rd;
    logic [DW-1:0] r_srt_rd;

    logic [AW-1:0] val_addr;
    logic          srt_we;
    logic          lt;
    logic [AW-1:0] rank_now;
    logic          last_j;
    logic          last_i;

    // Value store: written while loading, read by the scan
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_val[i_wr_addr] <= i_wr_data;
        end
        r_rd <= mem_val[val_addr];
    end

    // Sorted store: written at each entry's rank, read for emission
    always_ff @(posedge i_clk) begin
        if (srt_we) begin
            mem_srt[rank_now] <= r_key;
        end
        r_srt_rd <= mem_srt[i_rd_addr];
    end

    assign o_rd_data = r_srt_rd;

    // Shared comparator: ties break on index, so ranks form a permutation
    assign lt       = (r_rd < r_key) || ((r_rd == r_key) && (r_j < r_i));
    assign rank_now = r_rank + AW'(lt);
    assign last_j   = (CW'(r_j) + CW'(1)) == r_n;
    assign last_i   = (CW'(r_i) + CW'(1)) == r_n;

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n    <= n_n;
        r_i    <= n_i;
        r_j    <= n_j;
        r_rank <= n_rank;
        r_key  <= n_key;
    end

    // Advance the scan: one compare per cycle while scanning, paused for each key fetch
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_rank   = r_rank;
        n_key    = r_key;
        val_addr = r_i;
        srt_we   = 1'b0;
        o_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_i     = '0;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                val_addr = r_i;
                n_state  = S_CAP;
            end
            S_CAP: begin
                n_key    = r_rd;
                val_addr = '0;
                n_j      = '0;
                n_rank   = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                val_addr = AW'(r_j + 1'b1);
                n_j      = AW'(r_j + 1'b1);
                n_rank   = rank_now;
                if (last_j) begin
                    srt_we = 1'b1;
                    if (last_i) begin
                        o_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = AW'(r_i + 1'b1);
                        n_state = S_KEY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/lspsr_checker.sv]
// Port-level checks for the LSP stability check and rearrange block.
// Bound to lsp_stability_check_and_rearrange_unit; depends on nothing else.
`timescale 1ns / 1ps

module lspsr_checker #(
    parameter int TW = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [TW-1:0] o_m_tdata,
    input logic          o_m_tlast,
    input logic          o_m_tuser
);

    // Loading and emission never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is presented");

    // Input opens again right after the final result transfers
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && !o_m_tvalid))
        else $error("input not ready after final result");

    // A vector's results carry one status: it holds into the next result
    a_status_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> ##1 (o_m_tvalid && $stable(o_m_tuser)))
        else $error("status changed within a vector or result gap too long");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule

bind lsp_stability_check_and_rearrange_unit lspsr_checker #(
    .TW (OUT_TW)
) u_lspsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
